// ===== sv/crs_pkg.sv =====
// Shared types and constants for the coefficient ramp scheduler.
`timescale 1ns / 1ps

package crs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [VAL_W-1:0] ONE_VALUE = VAL_W'(1) << FRAC_BITS;
  localparam logic signed [VAL_W-1:0] VAL_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN   = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_INACTIVE  = 2'd0,
    MODE_HOLD      = 2'd1,
    MODE_LINEAR    = 2'd2,
    MODE_GEOMETRIC = 2'd3
  } crs_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE            = 3'd0,
    CFG_START_ITERATION = 3'd1,
    CFG_END_ITERATION   = 3'd2,
    CFG_START_VALUE     = 3'd3,
    CFG_END_VALUE       = 3'd4,
    CFG_ADD_STEP        = 3'd5,
    CFG_MUL_FACTOR      = 3'd6,
    CFG_CALLS_PER_STEP  = 3'd7
  } crs_cfg_idx_t;

  typedef struct packed {
    crs_mode_t                mode;
    logic [31:0]              start_iteration;
    logic [31:0]              end_iteration;
    logic signed [VAL_W-1:0]  start_value;
    logic signed [VAL_W-1:0]  end_value;
    logic signed [VAL_W-1:0]  add_step;
    logic [31:0]              mul_factor;
    logic [CNT_W-1:0]         calls_per_step;
  } crs_cfg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        count;
  } crs_state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    saturated;
  } crs_result_t;

endpackage

// ===== sv/coefficient_ramp_scheduler.sv =====
// Top level of the coefficient ramp scheduler: config registers, pipeline and state.
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_iteration[31:0], in_restart
// out_     output     out_valid/out_stall out_value[31:0] (signed), out_saturated
// cfg_     input      cfg_we              cfg_index[2:0], cfg_wdata[31:0]
//
// One transaction per cycle sustained while out_ does not stall; a result passes
// through the input register, then the result register.
// The cycle is set by the state loop: compare, add or 32x32 multiply, clamp,
// and back into the current value register.
// Reset (rst_n low, synchronous) clears the pipeline, the state and loads the
// register defaults (mul_factor 1.0, calls_per_step 1, the rest zero).
// A stall on out_ holds the result register; the input register keeps its
// transaction and in_stall rises only while both stages are full.

module coefficient_ramp_scheduler
  import crs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]             cfg_wdata,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [31:0]             in_iteration,
  input  logic                    in_restart,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_saturated
);

  crs_cfg_t    cfg_r;
  crs_state_t  state_r;
  crs_state_t  state_nxt;
  crs_result_t step_res;

  logic        s1_valid_r;
  logic [31:0] s1_iter_r;
  logic        s1_restart_r;
  logic        out_valid_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic        out_sat_r;

  logic        out_free;
  logic        s1_adv;

  // Result register can take a new transaction when empty or draining.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode            <= MODE_INACTIVE;
      cfg_r.start_iteration <= '0;
      cfg_r.end_iteration   <= '0;
      cfg_r.start_value     <= '0;
      cfg_r.end_value       <= '0;
      cfg_r.add_step        <= '0;
      cfg_r.mul_factor      <= 32'(ONE_VALUE);
      cfg_r.calls_per_step  <= CNT_W'(1);
    end else if (cfg_we) begin
      unique case (crs_cfg_idx_t'(cfg_index))
        CFG_MODE:            cfg_r.mode            <= crs_mode_t'(cfg_wdata[1:0]);
        CFG_START_ITERATION: cfg_r.start_iteration <= cfg_wdata;
        CFG_END_ITERATION:   cfg_r.end_iteration   <= cfg_wdata;
        CFG_START_VALUE:     cfg_r.start_value     <= signed'(cfg_wdata);
        CFG_END_VALUE:       cfg_r.end_value       <= signed'(cfg_wdata);
        CFG_ADD_STEP:        cfg_r.add_step        <= signed'(cfg_wdata);
        CFG_MUL_FACTOR:      cfg_r.mul_factor      <= cfg_wdata;
        CFG_CALLS_PER_STEP:  cfg_r.calls_per_step  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: capture whenever it is not held by a stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_iter_r    <= in_iteration;
      s1_restart_r <= in_restart;
    end
  end

  crs_step u_step (
    .cfg       (cfg_r),
    .state_cur (state_r),
    .iteration (s1_iter_r),
    .restart   (s1_restart_r),
    .state_nxt (state_nxt),
    .result    (step_res)
  );

  // Advance the state exactly once per transaction, as it moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_value_r <= step_res.value;
      out_sat_r   <= step_res.saturated;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;

endmodule

// ===== sv/crs_step.sv =====
// Combinational update of the scheduled coefficient for one iteration.
`timescale 1ns / 1ps

module crs_step
  import crs_pkg::*;
(
  input  crs_cfg_t    cfg,
  input  crs_state_t  state_cur,
  input  logic [31:0] iteration,
  input  logic        restart,
  output crs_state_t  state_nxt,
  output crs_result_t result
);

  logic signed [VAL_W-1:0]   cv;
  logic [CNT_W-1:0]          cnt;
  logic [CNT_W-1:0]          cnt_inc;
  logic                      in_window;
  logic signed [VAL_W:0]     sum;
  logic signed [VAL_W:0]     factor_s;
  logic signed [2*VAL_W-1:0] prod;
  logic signed [2*VAL_W-1:0] prod_q;
  logic signed [VAL_W-1:0]   add_val;
  logic                      add_sat;
  logic signed [VAL_W-1:0]   mul_val;
  logic                      mul_sat;

  // Restart clears the state ahead of this iteration's update.
  assign cv  = restart ? '0 : state_cur.value;
  assign cnt = restart ? '0 : state_cur.count;
  assign cnt_inc = cnt + CNT_W'(1);
  assign in_window = (iteration > cfg.start_iteration) && (iteration < cfg.end_iteration);

  // Saturating add
  assign sum     = {cv[VAL_W-1], cv} + {cfg.add_step[VAL_W-1], cfg.add_step};
  assign add_sat = sum[VAL_W] != sum[VAL_W-1];
  assign add_val = add_sat ? (sum[VAL_W] ? VAL_MIN : VAL_MAX) : sum[VAL_W-1:0];

  // Multiply by unsigned factor; arithmetic shift rounds toward minus infinity
  assign factor_s = signed'({1'b0, cfg.mul_factor});
  assign prod     = cv * factor_s;
  assign prod_q   = prod >>> FRAC_BITS;
  assign mul_sat  = !((&prod_q[2*VAL_W-1:VAL_W-1]) || !(|prod_q[2*VAL_W-1:VAL_W-1]));
  assign mul_val  = mul_sat ? (prod_q[2*VAL_W-1] ? VAL_MIN : VAL_MAX)
                            : prod_q[VAL_W-1:0];

  always_comb begin
    state_nxt.value  = cv;
    state_nxt.count  = cnt;
    result.value     = cv;
    result.saturated = 1'b0;
    unique case (cfg.mode)
      MODE_INACTIVE: begin
        result.value = ONE_VALUE;
      end
      MODE_HOLD: begin
        result.value = cfg.start_value;
      end
      MODE_LINEAR, MODE_GEOMETRIC: begin
        if (in_window) begin
          state_nxt.count = cnt_inc;
          if ((cfg.calls_per_step != '0) && (cnt_inc == cfg.calls_per_step)) begin
            state_nxt.count = '0;
            if (cfg.mode == MODE_LINEAR) begin
              state_nxt.value  = add_val;
              result.saturated = add_sat;
            end else begin
              state_nxt.value  = mul_val;
              result.saturated = mul_sat;
            end
          end
        end else begin
          // End iteration wins when both match
          if (iteration == cfg.end_iteration) begin
            state_nxt.value = cfg.end_value;
          end else if (iteration == cfg.start_iteration) begin
            state_nxt.value = cfg.start_value;
          end
        end
        result.value = state_nxt.value;
      end
      default: begin
        result.value = ONE_VALUE;
      end
    endcase
  end

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the coefficient ramp scheduler.
`timescale 1ns / 1ps

module testbench;
  import crs_pkg::*;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [31:0]             cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic [31:0]             in_iteration;
  logic                    in_restart;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_saturated;

  // Shadow copy of the register file and of the scheduler state. Both are
  // touched only when a transaction or a register write is accepted.
  crs_cfg_t    ramp_cfg;
  crs_state_t  ramp_state;

  // Coefficients still owed by the block, oldest first.
  crs_result_t expected_coeffs[$];

  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;

  coefficient_ramp_scheduler i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_iteration (in_iteration),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_saturated(out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("coefficient_ramp_scheduler regression: fail");
    $finish;
  end

  // Compute the coefficient for one accepted iteration and advance the
  // shadow state exactly as the block must.
  function automatic crs_result_t advance_ramp(input logic [31:0] iteration,
                                               input logic restart);
    crs_result_t coeff;
    longint      wide;
    coeff.saturated = 1'b0;
    coeff.value     = '0;
    // Restart clears the state in every mode, not just the ramp modes.
    if (restart) ramp_state = '0;
    case (ramp_cfg.mode)
      MODE_INACTIVE: coeff.value = ONE_VALUE;
      MODE_HOLD:     coeff.value = ramp_cfg.start_value;
      default: begin
        if (iteration > ramp_cfg.start_iteration && iteration < ramp_cfg.end_iteration) begin
          // Inside the window: count the call, step on the last one. A zero
          // step count keeps counting but never steps.
          ramp_state.count = ramp_state.count + 1;
          if (ramp_cfg.calls_per_step != 0 && ramp_state.count == ramp_cfg.calls_per_step) begin
            if (ramp_cfg.mode == MODE_LINEAR)
              wide = longint'($signed(ramp_state.value)) + longint'($signed(ramp_cfg.add_step));
            else
              // Arithmetic shift of the exact product rounds toward minus infinity.
              wide = (longint'($signed(ramp_state.value)) *
                      longint'({32'd0, ramp_cfg.mul_factor})) >>> FRAC_BITS;
            if (wide > longint'(VAL_MAX)) begin
              ramp_state.value = VAL_MAX;
              coeff.saturated  = 1'b1;
            end else if (wide < longint'(VAL_MIN)) begin
              ramp_state.value = VAL_MIN;
              coeff.saturated  = 1'b1;
            end else begin
              ramp_state.value = wide[31:0];
            end
            ramp_state.count = '0;
          end
        end else begin
          // Load start first, then end, so end wins when both match.
          if (iteration == ramp_cfg.start_iteration) ramp_state.value = ramp_cfg.start_value;
          if (iteration == ramp_cfg.end_iteration)   ramp_state.value = ramp_cfg.end_value;
        end
        coeff.value = ramp_state.value;
      end
    endcase
    return coeff;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
  endtask

  // Drive one transaction from a falling edge and hold it until accepted.
  // Random idle cycles go in front so gaps land on every pipeline phase.
  task automatic send_iteration(input logic [31:0] iteration, input logic restart);
    crs_result_t owed;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_iteration = iteration;
    in_restart   = restart;
    do @(posedge clk); while (in_stall !== 1'b0);
    owed = advance_ramp(iteration, restart);
    expected_coeffs.insert(expected_coeffs.size(), owed);
    @(negedge clk);
  endtask

  // Drop valid, wait for every owed result, then let the pipeline settle.
  task automatic drain_results();
    in_valid = 1'b0;
    while (expected_coeffs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One register write; call only from a falling edge with the block idle.
  task automatic cfg_write(input crs_cfg_idx_t idx, input logic [31:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      CFG_MODE:            ramp_cfg.mode            = crs_mode_t'(data[1:0]);
      CFG_START_ITERATION: ramp_cfg.start_iteration = data;
      CFG_END_ITERATION:   ramp_cfg.end_iteration   = data;
      CFG_START_VALUE:     ramp_cfg.start_value     = data;
      CFG_END_VALUE:       ramp_cfg.end_value       = data;
      CFG_ADD_STEP:        ramp_cfg.add_step        = data;
      CFG_MUL_FACTOR:      ramp_cfg.mul_factor      = data;
      CFG_CALLS_PER_STEP:  ramp_cfg.calls_per_step  = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic program_ramp(input crs_mode_t mode, input logic [31:0] first_it,
                              input logic [31:0] last_it, input logic [31:0] first_val,
                              input logic [31:0] last_val, input logic [31:0] step,
                              input logic [31:0] factor, input logic [31:0] calls);
    cfg_write(CFG_MODE, 32'(mode));
    cfg_write(CFG_START_ITERATION, first_it);
    cfg_write(CFG_END_ITERATION, last_it);
    cfg_write(CFG_START_VALUE, first_val);
    cfg_write(CFG_END_VALUE, last_val);
    cfg_write(CFG_ADD_STEP, step);
    cfg_write(CFG_MUL_FACTOR, factor);
    cfg_write(CFG_CALLS_PER_STEP, calls);
  endtask

  // Small signed values half the time, with the rails and full-range noise mixed in.
  function automatic logic [31:0] pick_fixed();
    case ($urandom_range(7))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  // Out of reset the block is inactive: every iteration returns 1.0.
  task automatic test_reset_defaults();
    send_iteration(32'h0000_0000, 1'b0);
    send_iteration(32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_hold_mode();
    drain_results();
    program_ramp(MODE_HOLD, 0, 0, VAL_MIN, 0, 0, ONE_VALUE, 1);
    send_iteration(32'd0, 1'b0);
    drain_results();
    cfg_write(CFG_START_VALUE, VAL_MAX);
    send_iteration(32'd7, 1'b1);
  endtask

  // Linear ramp into both rails, end load, hold outside the window, restart.
  task automatic test_linear_ramp();
    drain_results();
    program_ramp(MODE_LINEAR, 5, 9, 32'h7FFE_FFFF, 32'h0003_0000, 32'h0001_8000,
                 ONE_VALUE, 1);
    send_iteration(32'd5, 1'b0);
    send_iteration(32'd6, 1'b0);
    send_iteration(32'd7, 1'b0);
    send_iteration(32'd9, 1'b0);
    send_iteration(32'd10, 1'b0);
    send_iteration(32'd3, 1'b1);
    drain_results();
    cfg_write(CFG_START_VALUE, VAL_MIN + 1);
    cfg_write(CFG_ADD_STEP, VAL_MIN);
    send_iteration(32'd5, 1'b0);
    send_iteration(32'd6, 1'b0);
    // Start and end on the same iteration: the end value wins.
    drain_results();
    program_ramp(MODE_LINEAR, 100, 100, ONE_VALUE, 32'hFFFF_0000, 32'h0001_0000,
                 ONE_VALUE, 1);
    send_iteration(32'd100, 1'b0);
  endtask

  // Geometric ramp: floor rounding of negative products, rails, end load.
  task automatic test_geometric_ramp();
    drain_results();
    program_ramp(MODE_GEOMETRIC, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFD, 32'h0002_0000, 0,
                 32'h0000_8000, 2);
    send_iteration(32'd0, 1'b0);
    send_iteration(32'd1, 1'b0);
    send_iteration(32'd2, 1'b0);
    drain_results();
    cfg_write(CFG_MUL_FACTOR, 32'hFFFF_FFFF);
    cfg_write(CFG_CALLS_PER_STEP, 1);
    send_iteration(32'd3, 1'b0);
    drain_results();
    cfg_write(CFG_START_VALUE, VAL_MAX);
    send_iteration(32'd0, 1'b0);
    send_iteration(32'd4, 1'b0);
    send_iteration(32'hFFFF_FFFF, 1'b0);
    drain_results();
    cfg_write(CFG_START_VALUE, VAL_MIN);
    send_iteration(32'd0, 1'b0);
    send_iteration(32'd5, 1'b0);
  endtask

  // Zero calls per step never moves the value; restart while inactive
  // still clears the state, seen once the ramp mode returns.
  task automatic test_never_step();
    drain_results();
    program_ramp(MODE_LINEAR, 0, 50, 32'h0002_0000, 0, ONE_VALUE, ONE_VALUE, 0);
    send_iteration(32'd0, 1'b0);
    send_iteration(32'd1, 1'b0);
    drain_results();
    cfg_write(CFG_MODE, 32'(MODE_INACTIVE));
    send_iteration(32'd3, 1'b1);
    drain_results();
    cfg_write(CFG_MODE, 32'(MODE_LINEAR));
    send_iteration(32'd60, 1'b0);
  endtask

  task automatic randomize_ramp();
    crs_mode_t   mode;
    logic [31:0] first_it;
    logic [31:0] last_it;
    logic [31:0] factor;
    logic [31:0] calls;
    case ($urandom_range(9))
      0:          mode = MODE_INACTIVE;
      1:          mode = MODE_HOLD;
      2, 3, 4, 5: mode = MODE_LINEAR;
      default:    mode = MODE_GEOMETRIC;
    endcase
    case ($urandom_range(5))
      0:       first_it = $urandom;
      1:       first_it = 32'hFFFF_FFFF - $urandom_range(30);
      2:       first_it = 32'd0;
      default: first_it = $urandom_range(1000);
    endcase
    last_it = ($urandom_range(7) == 0) ? $urandom : first_it + $urandom_range(40);
    case ($urandom_range(5))
      0:       factor = $urandom;
      1:       factor = 32'd0;
      default: factor = $urandom_range(32'h0000_C000, 32'h0001_4000);
    endcase
    case ($urandom_range(7))
      0:       calls = 32'd0;
      1:       calls = $urandom;
      default: calls = $urandom_range(1, 4);
    endcase
    program_ramp(mode, first_it, last_it, pick_fixed(), pick_fixed(), pick_fixed(),
                 factor, calls);
  endtask

  // Sweeps through the window with random content, plus noise iterations.
  // Each idling setting gets two register settings; the sender pauses for
  // a full drain once in every segment.
  task automatic test_random_traffic();
    int          idle_by_phase[4]  = '{0, 68, 0, 27};
    int          stall_by_phase[4] = '{0, 0, 68, 27};
    int          sent;
    int          sweeps;
    int          len;
    logic [31:0] first;
    logic [31:0] reach;
    for (int ph = 0; ph < 4; ph++) begin
      for (int seg = 0; seg < 2; seg++) begin
        drain_results();
        send_idle_pct  = idle_by_phase[ph];
        recv_stall_pct = stall_by_phase[ph];
        randomize_ramp();
        sent   = 0;
        sweeps = 0;
        while (sent < 125) begin
          if (sweeps == 2) drain_results();
          sweeps++;
          if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
              send_iteration($urandom, $urandom_range(1));
              sent++;
            end
          end else begin
            first = ramp_cfg.start_iteration - $urandom_range(2);
            reach = ramp_cfg.end_iteration - first;
            len   = (reach > 44) ? 48 : int'(reach) + 3;
            for (int k = 0; k < len; k++) begin
              send_iteration(first + k,
                             (k == 0 && $urandom_range(3) == 0) || $urandom_range(49) == 0);
              sent++;
            end
          end
        end
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Receiver side: stall at random from the falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare every accepted result with the oldest owed coefficient.
  always @(posedge clk) begin
    crs_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_coeffs.size() == 0) begin
        note_mismatch("unexpected result value", 32'h0, out_value);
      end else begin
        want = expected_coeffs.pop_front();
        if (out_value !== want.value)
          note_mismatch("value", want.value, out_value);
        if (out_saturated !== want.saturated)
          note_mismatch("saturated flag", 32'(want.saturated), 32'(out_saturated));
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_MODE;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_iteration   = '0;
    in_restart     = 1'b0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Mirror the register defaults the block loads in reset.
    ramp_cfg                = '0;
    ramp_cfg.mode           = MODE_INACTIVE;
    ramp_cfg.mul_factor     = ONE_VALUE;
    ramp_cfg.calls_per_step = 1;
    ramp_state              = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_hold_mode();
    test_linear_ramp();
    test_geometric_ramp();
    test_never_step();
    test_random_traffic();
    drain_results();

    if (mismatches == 0 && expected_coeffs.size() == 0)
      $display("coefficient_ramp_scheduler regression: pass");
    else
      $display("coefficient_ramp_scheduler regression: fail");
    $finish;
  end

endmodule
